FILE: rtl/mjpf_pkg.sv
// ----------------------------------------------------------------------------
// mjpf_pkg
// Shared types, constants and saturation helpers for the multi-joint PID block.
// ----------------------------------------------------------------------------
package mjpf_pkg;

  localparam int JOINT_W         = 6;
  localparam int DATA_W          = 32;
  localparam int DT_W            = 16;
  localparam int CFG_INDEX_W     = 3;
  localparam int JOINT_COUNT_DEF = 64;
  localparam int DIV_W           = DATA_W + 1 + DT_W;
  localparam int DIGIT_W         = 4;
  localparam int DIGITS          = DATA_W / DIGIT_W;
  localparam int ACC_W           = 2 * DATA_W;
  localparam int SUM_W           = 52;
  localparam int FRAC_W          = 16;
  localparam int CNT_W           = 6;
  localparam int SEL_W           = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_GAIN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTEGRAL_GAIN    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DERIVATIVE_GAIN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_VELOCITY_GAIN    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTEGRAL_FLOOR   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTEGRAL_CEILING = 3'd5;

  localparam logic [SEL_W-1:0] SEL_INTEGRAL   = 3'd0;
  localparam logic [SEL_W-1:0] SEL_POSITION   = 3'd1;
  localparam logic [SEL_W-1:0] SEL_VELOCITY   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_INTEG_GAIN = 3'd3;
  localparam logic [SEL_W-1:0] SEL_DERIVATIVE = 3'd4;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sd2147483648);
  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh80000000;

  typedef struct packed {
    logic [JOINT_W-1:0]        joint_index;
    logic signed [DATA_W-1:0]  target_position;
    logic signed [DATA_W-1:0]  target_velocity;
    logic signed [DATA_W-1:0]  feedforward_effort;
    logic signed [DATA_W-1:0]  measured_position;
    logic signed [DATA_W-1:0]  measured_velocity;
    logic [DT_W-1:0]           time_step;
  } in_t;

  typedef struct packed {
    logic [JOINT_W-1:0]        joint_out;
    logic signed [DATA_W-1:0]  drive_force;
    logic                      force_saturated;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_RATE,
    ST_MUL,
    ST_FOLD,
    ST_WB,
    ST_DONE
  } state_t;

  function automatic logic is_sat32(input logic signed [SUM_W-1:0] x);
    return (x > SUM_MAX) || (x < SUM_MIN);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SUM_MAX) begin
      r = DATA_MAX;
    end else if (x < SUM_MIN) begin
      r = DATA_MIN;
    end else begin
      r = DATA_W'(x);
    end
    return r;
  endfunction

endpackage

FILE: rtl/multi_joint_pid_feedforward_top.sv
// ----------------------------------------------------------------------------
// multi_joint_pid_feedforward_top
// Per-joint PID with clamped integral and feedforward, one shared gain set.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. After reset a clearing pass zeroes the
// per-joint state, during which no input is taken. An item then passes through
// one state read, a radix-2 divider for the error rate (skipped when the time
// step is zero) and five products on a shared 4-bit digit-serial multiplier,
// plus write-back and output. An item whose joint is out of range goes from
// idle straight to output. The result register frees the input side while a
// result waits to be taken.
module multi_joint_pid_feedforward_top #(
  parameter int JOINT_COUNT = mjpf_pkg::JOINT_COUNT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [mjpf_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [mjpf_pkg::DATA_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  mjpf_pkg::in_t                           in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output mjpf_pkg::out_t                          out_data
);

  import mjpf_pkg::*;

  localparam int AW    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int RAM_W = 3 * DATA_W;

  state_t state, state_next;

  logic signed [DATA_W-1:0] position_gain, integral_gain, derivative_gain;
  logic signed [DATA_W-1:0] velocity_gain, integral_floor, integral_ceiling;

  in_t                      item;
  logic [AW-1:0]            clr_addr;
  logic signed [DATA_W-1:0] err, verr, rate_new, integ_old, integ_new;
  logic [DT_W-1:0]          rem;
  logic [DIV_W-1:0]         qr;
  logic                     neg;
  logic [CNT_W-1:0]         cnt;
  logic [SEL_W-1:0]         mul_sel;
  logic signed [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0]        mul_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SUM_W-1:0]  sum;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [RAM_W-1:0]         ram_wdata, ram_rdata;

  logic                     joint_ok;
  logic signed [DATA_W:0]   pos_diff, vel_diff, err_diff;
  logic signed [DATA_W-1:0] err_now, prev_rd;
  logic [DATA_W:0]          diff_mag;
  logic [DT_W:0]            trial;
  logic                     fits;
  logic [DIGIT_W-1:0]       dig;
  logic signed [DIGIT_W:0]  dig_s;
  logic signed [DATA_W+DIGIT_W:0] term;
  logic signed [ACC_W-1:0]  acc_next, prod;
  logic signed [SUM_W-1:0]  integ_sum, integ_clamped;
  logic signed [DATA_W-1:0] rate_div;

  mjpf_ram #(
    .WIDTH(RAM_W),
    .DEPTH(JOINT_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position_gain    <= '0;
      integral_gain    <= '0;
      derivative_gain  <= '0;
      velocity_gain    <= '0;
      integral_floor   <= '0;
      integral_ceiling <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_POSITION_GAIN:    position_gain    <= cfg_data;
        CFG_INTEGRAL_GAIN:    integral_gain    <= cfg_data;
        CFG_DERIVATIVE_GAIN:  derivative_gain  <= cfg_data;
        CFG_VELOCITY_GAIN:    velocity_gain    <= cfg_data;
        CFG_INTEGRAL_FLOOR:   integral_floor   <= cfg_data;
        CFG_INTEGRAL_CEILING: integral_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath arithmetic
  always_comb begin
    joint_ok = 32'(in_data.joint_index) < 32'(JOINT_COUNT);
    prev_rd  = ram_rdata[3*DATA_W-1:2*DATA_W];
    pos_diff = (DATA_W+1)'(item.target_position) - (DATA_W+1)'(item.measured_position);
    vel_diff = (DATA_W+1)'(item.target_velocity) - (DATA_W+1)'(item.measured_velocity);
    err_now  = sat32(SUM_W'(pos_diff));
    err_diff = (DATA_W+1)'(err_now) - (DATA_W+1)'(prev_rd);
    diff_mag = err_diff[DATA_W] ? (DATA_W+1)'(0) - err_diff : err_diff;

    trial = {rem, qr[DIV_W-1]};
    fits  = trial >= {1'b0, item.time_step};

    if (neg) begin
      rate_div = (qr > DIV_W'(64'd2147483648)) ? DATA_MIN : -$signed(qr[DATA_W-1:0]);
    end else begin
      rate_div = (qr > DIV_W'(64'd2147483647)) ? DATA_MAX : $signed(qr[DATA_W-1:0]);
    end

    dig      = mul_b[DATA_W-1 -: DIGIT_W];
    dig_s    = (cnt == '0) ? $signed({dig[DIGIT_W-1], dig}) : $signed({1'b0, dig});
    term     = mul_a * dig_s;
    acc_next = ((cnt == '0) ? ACC_W'(0) : (acc <<< DIGIT_W)) + ACC_W'(term);
    prod     = acc >>> FRAC_W;

    integ_sum     = SUM_W'(integ_old) + SUM_W'(prod);
    integ_clamped = integ_sum;
    if (integ_clamped > SUM_W'(integral_ceiling)) begin
      integ_clamped = SUM_W'(integral_ceiling);
    end
    if (integ_clamped < SUM_W'(integral_floor)) begin
      integ_clamped = SUM_W'(integral_floor);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == AW'(JOINT_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = joint_ok ? ST_READ : ST_DONE;
      ST_READ:  state_next = (item.time_step != '0) ? ST_DIV : ST_MUL;
      ST_DIV:   if (cnt == CNT_W'(DIV_W - 1)) state_next = ST_RATE;
      ST_RATE:  state_next = ST_MUL;
      ST_MUL:   if (cnt == CNT_W'(DIGITS - 1)) state_next = ST_FOLD;
      ST_FOLD:  state_next = (mul_sel == SEL_DERIVATIVE) ? ST_WB : ST_MUL;
      ST_WB:    state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    ram_we    = (state == ST_CLEAR) || (state == ST_WB);
    ram_waddr = (state == ST_CLEAR) ? clr_addr : AW'(item.joint_index);
    ram_wdata = (state == ST_CLEAR) ? RAM_W'(0) : {err, rate_new, integ_new};
    ram_raddr = AW'(in_data.joint_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        item <= in_data;
        sum  <= '0;
      end
      ST_READ: begin
        err       <= err_now;
        verr      <= sat32(SUM_W'(vel_diff));
        rate_new  <= ram_rdata[2*DATA_W-1:DATA_W];
        integ_old <= ram_rdata[DATA_W-1:0];
        neg       <= err_diff[DATA_W];
        qr        <= {diff_mag, {DT_W{1'b0}}};
        rem       <= '0;
        cnt       <= '0;
        mul_sel   <= SEL_INTEGRAL;
        mul_a     <= err_now;
        mul_b     <= DATA_W'(item.time_step);
        sum       <= SUM_W'(item.feedforward_effort);
      end
      ST_DIV: begin
        rem <= fits ? DT_W'(trial - {1'b0, item.time_step}) : DT_W'(trial);
        qr  <= {qr[DIV_W-2:0], fits};
        cnt <= cnt + CNT_W'(1);
      end
      ST_RATE: begin
        rate_new <= rate_div;
        cnt      <= '0;
      end
      ST_MUL: begin
        acc   <= acc_next;
        mul_b <= mul_b << DIGIT_W;
        cnt   <= cnt + CNT_W'(1);
      end
      ST_FOLD: begin
        cnt     <= '0;
        mul_sel <= mul_sel + SEL_W'(1);
        if (mul_sel == SEL_INTEGRAL) begin
          integ_new <= DATA_W'(integ_clamped);
        end else begin
          sum <= sum + SUM_W'(prod);
        end
        case (mul_sel)
          SEL_INTEGRAL: begin
            mul_a <= position_gain;
            mul_b <= err;
          end
          SEL_POSITION: begin
            mul_a <= velocity_gain;
            mul_b <= verr;
          end
          SEL_VELOCITY: begin
            mul_a <= integral_gain;
            mul_b <= integ_new;
          end
          default: begin
            mul_a <= derivative_gain;
            mul_b <= rate_new;
          end
        endcase
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_data.joint_out       <= item.joint_index;
      out_data.drive_force     <= sat32(sum);
      out_data.force_saturated <= is_sat32(sum);
    end
  end

`ifndef SYNTHESIS
  a_no_input_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready)
    else $error("input taken during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.force_saturated |->
      (out_data.drive_force == DATA_MAX || out_data.drive_force == DATA_MIN))
    else $error("saturation flag without extreme force");
`endif

endmodule

FILE: rtl/mjpf_ram.sv
// ----------------------------------------------------------------------------
// mjpf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mjpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
